@@ design/morse_keying_encoder_defines.svh @@
// ----------------------------------------------------------------------------
// morse keying encoder assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef MORSE_KEYING_ENCODER_DEFINES_SVH
`define MORSE_KEYING_ENCODER_DEFINES_SVH

// same-cycle implication
`define MKE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MKE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mke_pkg.sv @@
// ----------------------------------------------------------------------------
// mke_pkg
// types, constants and the morse code table of the keying encoder
// ----------------------------------------------------------------------------
package mke_pkg;

    localparam int CODE_SLOTS = 8;
    localparam int LEN_W      = 4;

    localparam logic [7:0]  CHAR_SPACE       = 8'h20;
    localparam logic [7:0]  CHAR_LOWER_A     = 8'h61;
    localparam logic [7:0]  CHAR_LOWER_Z     = 8'h7a;
    localparam logic [7:0]  CASE_OFFSET      = 8'd32;
    localparam logic [15:0] UNIT_TICKS_RESET = 16'd250;
    localparam logic        REG_UNIT_TICKS   = 1'b0;

    // code bits are left aligned, first element in the msb, dash = 1
    typedef struct packed {
        logic                  valid;
        logic [LEN_W-1:0]      len;
        logic [CODE_SLOTS-1:0] bits;
    } mke_code_t;

    // start-of-character command to the segment sequencer
    typedef struct packed {
        logic gap;
        logic space;
        logic coded;
        logic last;
    } mke_cmd_t;

    function automatic mke_code_t mke_lookup(input logic [7:0] c);
        mke_code_t r;
        r = '{1'b1, 4'd0, 8'b0000_0000};
        case (c)
            "A":   r = '{1'b1, 4'd2, 8'b0100_0000};
            "B":   r = '{1'b1, 4'd4, 8'b1000_0000};
            "C":   r = '{1'b1, 4'd4, 8'b1010_0000};
            "D":   r = '{1'b1, 4'd3, 8'b1000_0000};
            "E":   r = '{1'b1, 4'd1, 8'b0000_0000};
            "F":   r = '{1'b1, 4'd4, 8'b0010_0000};
            "G":   r = '{1'b1, 4'd3, 8'b1100_0000};
            "H":   r = '{1'b1, 4'd4, 8'b0000_0000};
            "I":   r = '{1'b1, 4'd2, 8'b0000_0000};
            "J":   r = '{1'b1, 4'd4, 8'b0111_0000};
            "K":   r = '{1'b1, 4'd3, 8'b1010_0000};
            "L":   r = '{1'b1, 4'd4, 8'b0100_0000};
            "M":   r = '{1'b1, 4'd2, 8'b1100_0000};
            "N":   r = '{1'b1, 4'd2, 8'b1000_0000};
            "O":   r = '{1'b1, 4'd3, 8'b1110_0000};
            "P":   r = '{1'b1, 4'd4, 8'b0110_0000};
            "Q":   r = '{1'b1, 4'd4, 8'b1101_0000};
            "R":   r = '{1'b1, 4'd3, 8'b0100_0000};
            "S":   r = '{1'b1, 4'd3, 8'b0000_0000};
            "T":   r = '{1'b1, 4'd1, 8'b1000_0000};
            "U":   r = '{1'b1, 4'd3, 8'b0010_0000};
            "V":   r = '{1'b1, 4'd4, 8'b0001_0000};
            "W":   r = '{1'b1, 4'd3, 8'b0110_0000};
            "X":   r = '{1'b1, 4'd4, 8'b1001_0000};
            "Y":   r = '{1'b1, 4'd4, 8'b1011_0000};
            "Z":   r = '{1'b1, 4'd4, 8'b1100_0000};
            "0":   r = '{1'b1, 4'd5, 8'b1111_1000};
            "1":   r = '{1'b1, 4'd5, 8'b0111_1000};
            "2":   r = '{1'b1, 4'd5, 8'b0011_1000};
            "3":   r = '{1'b1, 4'd5, 8'b0001_1000};
            "4":   r = '{1'b1, 4'd5, 8'b0000_1000};
            "5":   r = '{1'b1, 4'd5, 8'b0000_0000};
            "6":   r = '{1'b1, 4'd5, 8'b1000_0000};
            "7":   r = '{1'b1, 4'd5, 8'b1100_0000};
            "8":   r = '{1'b1, 4'd5, 8'b1110_0000};
            "9":   r = '{1'b1, 4'd5, 8'b1111_0000};
            8'h2e: r = '{1'b1, 4'd6, 8'b0101_0100};
            8'h2d: r = '{1'b1, 4'd6, 8'b1000_0100};
            8'h3a: r = '{1'b1, 4'd6, 8'b1110_0000};
            8'h2c: r = '{1'b1, 4'd6, 8'b1100_1100};
            8'h3f: r = '{1'b1, 4'd6, 8'b0011_0000};
            8'h27: r = '{1'b1, 4'd6, 8'b0111_1000};
            8'h21: r = '{1'b1, 4'd6, 8'b1010_1100};
            8'h40: r = '{1'b1, 4'd6, 8'b0110_1000};
            default: r = '{1'b0, 4'd0, 8'b0000_0000};
        endcase
        return r;
    endfunction

endpackage

@@ design/mke_seq.sv @@
// ----------------------------------------------------------------------------
// mke_seq
// segment sequencer: shifts out one code element at a time and emits gap,
// tone, silence, word-space and message-end segments through an output register
// ----------------------------------------------------------------------------
module mke_seq
    import mke_pkg::*;
#(
    parameter int MAX_CODE_ELEMENTS = 6,
    parameter int CW                = $clog2(MAX_CODE_ELEMENTS + 1)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  mke_cmd_t                     cmd,
    input  logic [MAX_CODE_ELEMENTS-1:0] code,
    input  logic [CW-1:0]                count,
    input  logic [15:0]                  unit_ticks,
    output logic                         busy,
    output logic                         seg_valid,
    input  logic                         seg_ready,
    output logic                         tone_on,
    output logic [18:0]                  duration_ticks,
    output logic                         run_last
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_GAP   = 6'b000010,
        S_TONE  = 6'b000100,
        S_SIL   = 6'b001000,
        S_SPACE = 6'b010000,
        S_END   = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        UNITS_1 = 2'b00,
        UNITS_3 = 2'b01,
        UNITS_7 = 2'b10
    } units_t;

    state_t                       state_reg, state_next, state_after, state_first;
    logic [MAX_CODE_ELEMENTS-1:0] code_reg, code_next;
    logic [CW-1:0]                count_reg, count_next;
    logic                         last_reg, last_next;
    logic                         valid_reg, valid_next;
    logic                         tone_reg, tone_next;
    logic [18:0]                  dur_reg, dur_next;
    logic                         run_last_reg, run_last_next;
    logic                         advance;
    logic                         seg_tone;
    units_t                       seg_units;
    logic [18:0]                  dur_1, dur_3, dur_7;

    assign busy    = (state_reg != S_IDLE);
    assign advance = busy && (!valid_reg || seg_ready);

    assign dur_1 = {3'b000, unit_ticks};
    assign dur_3 = dur_1 + {dur_1[17:0], 1'b0};
    assign dur_7 = {dur_1[15:0], 3'b000} - dur_1;

    always_comb
    begin
        seg_tone    = 1'b0;
        seg_units   = UNITS_1;
        state_after = S_IDLE;
        unique case (state_reg)
            S_GAP:
            begin
                seg_units   = UNITS_3;
                state_after = S_TONE;
            end
            S_TONE:
            begin
                seg_tone    = 1'b1;
                seg_units   = code_reg[MAX_CODE_ELEMENTS-1] ? UNITS_3 : UNITS_1;
                state_after = S_SIL;
            end
            S_SIL:
            begin
                if (count_reg != '0)
                    state_after = S_TONE;
                else if (last_reg)
                    state_after = S_END;
                else
                    state_after = S_IDLE;
            end
            S_SPACE:
            begin
                seg_units   = UNITS_7;
                state_after = last_reg ? S_END : S_IDLE;
            end
            S_END:
            begin
                seg_units   = UNITS_7;
                state_after = S_IDLE;
            end
            default:
            begin
                state_after = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.space)
            state_first = S_SPACE;
        else if (cmd.coded)
            state_first = cmd.gap ? S_GAP : S_TONE;
        else if (cmd.last)
            state_first = S_END;
        else
            state_first = S_IDLE;
    end

    always_comb
    begin
        state_next    = state_reg;
        code_next     = code_reg;
        count_next    = count_reg;
        last_next     = last_reg;
        valid_next    = valid_reg;
        tone_next     = tone_reg;
        dur_next      = dur_reg;
        run_last_next = run_last_reg;

        if (seg_ready)
            valid_next = 1'b0;

        if (load)
        begin
            state_next = state_first;
            code_next  = code;
            count_next = count;
            last_next  = cmd.last;
        end
        else if (advance)
        begin
            state_next    = state_after;
            valid_next    = 1'b1;
            tone_next     = seg_tone;
            run_last_next = (state_after == S_IDLE);
            case (seg_units)
                UNITS_3: dur_next = dur_3;
                UNITS_7: dur_next = dur_7;
                default: dur_next = dur_1;
            endcase
            if (state_reg == S_TONE)
            begin
                code_next  = {code_reg[MAX_CODE_ELEMENTS-2:0], 1'b0};
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        count_reg    <= count_next;
        last_reg     <= last_next;
        tone_reg     <= tone_next;
        dur_reg      <= dur_next;
        run_last_reg <= run_last_next;
    end

    assign seg_valid      = valid_reg;
    assign tone_on        = tone_reg;
    assign duration_ticks = dur_reg;
    assign run_last       = run_last_reg;

endmodule

@@ design/morse_keying_encoder.sv @@
// ----------------------------------------------------------------------------
// morse_keying_encoder
// turns message characters into keyed tone and silence segments
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  char      char_valid / char_ready    char_code, message_end
//  seg       seg_valid / seg_ready      tone_on, duration_ticks, run_last
//  apb       psel, penable, pready      paddr, pwrite, pwdata, prdata
//
//  a character with segments holds char_ready low after its transfer until
//  its last segment is in the output register; a character with no
//  segments leaves char_ready high. the sequencer emits one segment per
//  cycle while seg_ready is high, one code element shifted out per tone. a
//  stall on seg holds the output register and the sequencer. reset clears
//  the pending letter gap and sets unit_ticks to 250.
// ----------------------------------------------------------------------------
module morse_keying_encoder
    import mke_pkg::*;
#(
    parameter int MAX_CODE_ELEMENTS = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        char_valid,
    output logic        char_ready,
    input  logic [7:0]  char_code,
    input  logic        message_end,
    output logic        seg_valid,
    input  logic        seg_ready,
    output logic        tone_on,
    output logic [18:0] duration_ticks,
    output logic        run_last
);

    localparam int CW = $clog2(MAX_CODE_ELEMENTS + 1);

    logic [15:0]                  unit_ticks_reg, unit_ticks_next;
    logic                         pending_reg, pending_next;
    logic                         cfg_wr;
    logic                         accept;
    logic                         busy;
    logic [7:0]                   char_up;
    mke_code_t                    lookup;
    mke_cmd_t                     cmd;
    logic [CW-1:0]                count;
    logic [MAX_CODE_ELEMENTS-1:0] code;
    logic                         is_space;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_UNIT_TICKS);
    assign prdata = (paddr[2] == REG_UNIT_TICKS) ? {16'h0000, unit_ticks_reg} : 32'h0;
    assign unit_ticks_next = cfg_wr ? pwdata[15:0] : unit_ticks_reg;

    // character decode
    assign char_ready = !busy;
    assign accept     = char_valid && char_ready;
    assign char_up    = ((char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_Z))
                        ? (char_code - CASE_OFFSET) : char_code;
    assign lookup     = mke_lookup(char_up);
    assign is_space   = (char_up == CHAR_SPACE);
    assign code       = lookup.bits[CODE_SLOTS-1 -: MAX_CODE_ELEMENTS];
    assign count      = (32'(lookup.len) > MAX_CODE_ELEMENTS)
                        ? CW'(MAX_CODE_ELEMENTS) : CW'(lookup.len);

    assign cmd.gap   = lookup.valid && pending_reg;
    assign cmd.space = is_space;
    assign cmd.coded = lookup.valid;
    assign cmd.last  = message_end;

    always_comb
    begin
        pending_next = pending_reg;
        if (accept)
        begin
            if (is_space || message_end)
                pending_next = 1'b0;
            else if (lookup.valid)
                pending_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg <= UNIT_TICKS_RESET;
            pending_reg    <= 1'b0;
        end
        else
        begin
            unit_ticks_reg <= unit_ticks_next;
            pending_reg    <= pending_next;
        end
    end

    mke_seq #(
        .MAX_CODE_ELEMENTS (MAX_CODE_ELEMENTS),
        .CW                (CW)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (accept),
        .cmd            (cmd),
        .code           (code),
        .count          (count),
        .unit_ticks     (unit_ticks_reg),
        .busy           (busy),
        .seg_valid      (seg_valid),
        .seg_ready      (seg_ready),
        .tone_on        (tone_on),
        .duration_ticks (duration_ticks),
        .run_last       (run_last)
    );

endmodule

@@ design/mke_checker.sv @@
// ----------------------------------------------------------------------------
// mke_checker
// port-level checks of the morse keying encoder, bound to the top level
// ----------------------------------------------------------------------------
`include "morse_keying_encoder_defines.svh"

module mke_checker
    import mke_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        char_valid,
    input logic        char_ready,
    input logic [7:0]  char_code,
    input logic        seg_valid,
    input logic        seg_ready,
    input logic        tone_on,
    input logic [18:0] duration_ticks,
    input logic        run_last
);

    logic        seg_stall;
    logic        seg_xfer;
    logic        space_xfer;
    logic [20:0] seg_payload;

    assign seg_stall   = seg_valid && !seg_ready;
    assign seg_xfer    = seg_valid && seg_ready;
    assign space_xfer  = char_valid && char_ready && (char_code == CHAR_SPACE);
    assign seg_payload = {tone_on, duration_ticks, run_last};

    // stalled segment holds
    `MKE_ASSERT_NEXT(a_seg_hold, seg_stall, seg_valid && $stable(seg_payload), "segment not held")

    // a tone is never the last segment of a character
    `MKE_ASSERT_NOW(a_tone_not_last, seg_valid && tone_on, !run_last, "tone segment marked last")

    // every tone is followed at once by its silence
    `MKE_ASSERT_NEXT(a_tone_sil, seg_xfer && tone_on, seg_valid && !tone_on, "missing silence")

    // a space always produces output, so the char side must stall
    `MKE_ASSERT_NEXT(a_space_busy, space_xfer, !char_ready, "space left char side ready")

endmodule

bind morse_keying_encoder mke_checker u_mke_checker (.*);
